[rtl/baseline_extent_tracker_top_defines.svh]
// ----------------------------------------------------------------------------
// Baseline extent tracker: assertion macros
// Shared property macros for the tracker's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef BASELINE_EXTENT_TRACKER_TOP_DEFINES_SVH
`define BASELINE_EXTENT_TRACKER_TOP_DEFINES_SVH

// same-cycle implication, sampled on the clock, muted during reset
`define BET_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the clock, muted during reset
`define BET_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/bet_pkg.sv]
// ----------------------------------------------------------------------------
// Baseline extent tracker package
// Fixed widths, bound reset values, register indexes and sequencer codes.
// ----------------------------------------------------------------------------
package bet_pkg;

   localparam int COORD_W = 32;
   localparam int CHAN_W  = 16;
   localparam int BOUND_W = 40;
   localparam int SCALE_W = 32;
   localparam int CSR_IDX_W = 8;

   typedef logic signed [BOUND_W-1:0] bound_type;
   typedef logic        [CSR_IDX_W-1:0] csr_idx_type;

   // bound reset values: most positive / most negative 40-bit numbers
   localparam bound_type BOUND_HI = {1'b0, {(BOUND_W-1){1'b1}}};
   localparam bound_type BOUND_LO = {1'b1, {(BOUND_W-1){1'b0}}};

   localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};

   // configuration register indexes
   localparam csr_idx_type CSR_FREQ_SCALE = 8'd0;
   localparam csr_idx_type CSR_STEP_SCALE = 8'd1;

   // sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RUN    = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   // sequencer step numbers
   localparam logic [3:0] STEP_SCALE_FIRST = 4'd0;
   localparam logic [3:0] STEP_SCALE_LAST  = 4'd1;
   localparam logic [3:0] STEP_FINAL       = 4'd8;

endpackage

[rtl/baseline_extent_tracker_top.sv]
// ----------------------------------------------------------------------------
// Baseline extent tracker
// Scales each row's u, v, w to wavelengths at the first and last channel and
// keeps per-set minima and maxima; emits the bounds on the last row of a set.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  coords, channel range, last mark
//  rsp      out        rsp_valid / rsp_ready  six bounds, any_included
//  csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// A row with a nonempty range passes from accept to the next ready through
// nine steps on the one 33x33 signed multiplier (two channel scales, six
// coordinate products, one trailing compare) and then the finish state.
// An empty row goes straight to the finish state. Bounds are compared one
// product per cycle. A finished set waits in the finish state only while an
// earlier result beat is still held on rsp. Reset is synchronous and clears
// bounds and config. csr_ready is always high.
// ----------------------------------------------------------------------------
`include "baseline_extent_tracker_top_defines.svh"

module baseline_extent_tracker_top #(
   parameter int CHANNEL_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   // row input
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [31:0]  req_coord_u,
   input  logic signed [31:0]  req_coord_v,
   input  logic signed [31:0]  req_coord_w,
   input  logic        [15:0]  req_first_channel,
   input  logic        [15:0]  req_end_channel,
   input  logic                req_last_of_set,
   // result output
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [39:0]  rsp_min_u,
   output logic signed [39:0]  rsp_max_u,
   output logic signed [39:0]  rsp_min_v,
   output logic signed [39:0]  rsp_max_v,
   output logic signed [39:0]  rsp_min_w,
   output logic signed [39:0]  rsp_max_w,
   output logic                rsp_any_included,
   // configuration writes
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic        [7:0]   csr_index,
   input  logic        [31:0]  csr_data
);

   // channel mask, saturating at the field width
   localparam logic [15:0] CH_MASK = 16'((64'd1 << CHANNEL_BITS) - 64'd1);

   // configuration
   logic        [31:0] freq_ff;
   logic        [31:0] step_ff;

   // control
   logic        [1:0]  state_ff, state_in;
   logic        [3:0]  step_cnt_ff, step_cnt_in;
   logic               last_ff;
   logic               row_included_ff, row_included_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // row payload
   logic signed [31:0] coord_ff [3];
   logic        [15:0] ch_first_ff;
   logic        [15:0] ch_last_ff;

   // shared multiplier and its product register
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [65:0] mul_result;
   logic        [63:0] prod_ff;

   // channel scales
   logic        [31:0] scale_first_ff;
   logic        [31:0] scale_last_ff;
   logic signed [49:0] scale_sum;
   logic        [31:0] scale_sat;

   // bounds
   bet_pkg::bound_type lowest_ff  [3];
   bet_pkg::bound_type highest_ff [3];
   bet_pkg::bound_type scaled_val;
   logic        [1:0]  mul_sel;
   logic        [1:0]  upd_sel;
   logic               upd_min;
   logic               upd_active;

   // result register
   bet_pkg::bound_type rsp_lo_ff [3];
   bet_pkg::bound_type rsp_hi_ff [3];
   logic               rsp_any_ff;

   logic        [15:0] ch_first_m;
   logic        [15:0] ch_end_m;
   logic               row_nonempty;
   logic               req_beat;
   logic               emit;

   // input decode
   assign ch_first_m   = req_first_channel & CH_MASK;
   assign ch_end_m     = req_end_channel & CH_MASK;
   assign row_nonempty = ch_end_m > ch_first_m;
   assign req_ready    = (state_ff == bet_pkg::ST_IDLE);
   assign req_beat     = req_valid && req_ready;
   assign csr_ready    = 1'b1;

   // result leaves only when the output register is free
   assign emit = (state_ff == bet_pkg::ST_FINISH) && last_ff &&
                 (!rsp_valid_ff || rsp_ready);

   // coordinate picked for the multiply and for the compare
   always_comb begin
      case (step_cnt_ff)
         4'd2, 4'd3: mul_sel = 2'd0;
         4'd4, 4'd5: mul_sel = 2'd1;
         4'd6, 4'd7: mul_sel = 2'd2;
         default:    mul_sel = 2'd0;
      endcase
      case (step_cnt_ff)
         4'd3, 4'd4: upd_sel = 2'd0;
         4'd5, 4'd6: upd_sel = 2'd1;
         4'd7, 4'd8: upd_sel = 2'd2;
         default:    upd_sel = 2'd0;
      endcase
   end

   // multiplier operands: step times channel, then coordinate times scale
   always_comb begin
      case (step_cnt_ff)
         bet_pkg::STEP_SCALE_FIRST: begin
            mul_a = {step_ff[31], step_ff};
            mul_b = {17'd0, ch_first_ff};
         end
         bet_pkg::STEP_SCALE_LAST: begin
            mul_a = {step_ff[31], step_ff};
            mul_b = {17'd0, ch_last_ff};
         end
         default: begin
            mul_a = {coord_ff[mul_sel][31], coord_ff[mul_sel]};
            mul_b = {1'b0, (step_cnt_ff[0] ? scale_last_ff : scale_first_ff)};
         end
      endcase
   end

   assign mul_result = mul_a * mul_b;

   // scale = freq + channel * step, clamped to the unsigned 32-bit range
   assign scale_sum = $signed({18'd0, freq_ff}) + $signed({prod_ff[48], prod_ff[48:0]});
   always_comb begin
      if (scale_sum[49]) begin
         scale_sat = 32'd0;
      end else if (|scale_sum[48:32]) begin
         scale_sat = bet_pkg::SCALE_MAX;
      end else begin
         scale_sat = scale_sum[31:0];
      end
   end

   // floor shift by 24 is a plain bit-select of the product
   assign scaled_val = $signed(prod_ff[63:24]);
   // first-channel value of a non-negative coordinate, or last-channel value
   // of a negative one, goes to the minimum
   assign upd_min    = (!step_cnt_ff[0]) == coord_ff[upd_sel][31];
   assign upd_active = (state_ff == bet_pkg::ST_RUN) && (step_cnt_ff >= 4'd3);

   // sequencer
   always_comb begin
      state_in        = state_ff;
      step_cnt_in     = step_cnt_ff;
      row_included_in = row_included_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         bet_pkg::ST_IDLE: begin
            if (req_beat) begin
               step_cnt_in = bet_pkg::STEP_SCALE_FIRST;
               if (row_nonempty) begin
                  state_in        = bet_pkg::ST_RUN;
                  row_included_in = 1'b1;
               end else begin
                  state_in = bet_pkg::ST_FINISH;
               end
            end
         end
         bet_pkg::ST_RUN: begin
            if (step_cnt_ff == bet_pkg::STEP_FINAL) begin
               state_in = bet_pkg::ST_FINISH;
            end else begin
               step_cnt_in = step_cnt_ff + 4'd1;
            end
         end
         bet_pkg::ST_FINISH: begin
            if (!last_ff) begin
               state_in = bet_pkg::ST_IDLE;
            end else if (emit) begin
               state_in        = bet_pkg::ST_IDLE;
               rsp_valid_in    = 1'b1;
               row_included_in = 1'b0;
            end
         end
         default: begin
            state_in = bet_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers, configuration and bounds
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= bet_pkg::ST_IDLE;
         step_cnt_ff     <= bet_pkg::STEP_SCALE_FIRST;
         row_included_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         freq_ff         <= 32'd0;
         step_ff         <= 32'd0;
         for (int j = 0; j < 3; j++) begin
            lowest_ff[j]  <= bet_pkg::BOUND_HI;
            highest_ff[j] <= bet_pkg::BOUND_LO;
         end
      end else begin
         state_ff        <= state_in;
         step_cnt_ff     <= step_cnt_in;
         row_included_ff <= row_included_in;
         rsp_valid_ff    <= rsp_valid_in;
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bet_pkg::CSR_FREQ_SCALE: freq_ff <= csr_data;
               bet_pkg::CSR_STEP_SCALE: step_ff <= csr_data;
               default: ;
            endcase
         end
         // one bound compare per step, then clear when the set leaves
         if (emit) begin
            for (int j = 0; j < 3; j++) begin
               lowest_ff[j]  <= bet_pkg::BOUND_HI;
               highest_ff[j] <= bet_pkg::BOUND_LO;
            end
         end else if (upd_active) begin
            if (upd_min) begin
               if (scaled_val < lowest_ff[upd_sel]) lowest_ff[upd_sel] <= scaled_val;
            end else begin
               if (scaled_val > highest_ff[upd_sel]) highest_ff[upd_sel] <= scaled_val;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         coord_ff[0] <= req_coord_u;
         coord_ff[1] <= req_coord_v;
         coord_ff[2] <= req_coord_w;
         ch_first_ff <= ch_first_m;
         ch_last_ff  <= ch_end_m - 16'd1;
         last_ff     <= req_last_of_set;
      end
      prod_ff <= mul_result[63:0];
      if (state_ff == bet_pkg::ST_RUN && step_cnt_ff == 4'd1) scale_first_ff <= scale_sat;
      if (state_ff == bet_pkg::ST_RUN && step_cnt_ff == 4'd2) scale_last_ff  <= scale_sat;
      if (emit) begin
         for (int j = 0; j < 3; j++) begin
            rsp_lo_ff[j] <= lowest_ff[j];
            rsp_hi_ff[j] <= highest_ff[j];
         end
         rsp_any_ff <= row_included_ff;
      end
   end

   // result ports
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_min_u        = rsp_lo_ff[0];
   assign rsp_max_u        = rsp_hi_ff[0];
   assign rsp_min_v        = rsp_lo_ff[1];
   assign rsp_max_v        = rsp_hi_ff[1];
   assign rsp_min_w        = rsp_lo_ff[2];
   assign rsp_max_w        = rsp_hi_ff[2];
   assign rsp_any_included = rsp_any_ff;

   // checks
   `BET_ASSERT_NEXT(a_empty_row_skips, req_beat && !row_nonempty, state_ff == bet_pkg::ST_FINISH, "empty row entered the multiply steps")
   `BET_ASSERT_NEXT(a_row_marks_included, req_beat && row_nonempty, row_included_ff, "nonempty row not marked as included")
   `BET_ASSERT_NOW(a_cleared_on_emit, $rose(rsp_valid_ff), !row_included_ff && lowest_ff[0] == bet_pkg::BOUND_HI, "state not cleared after result")
   `BET_ASSERT_NOW(a_step_bounded, state_ff == bet_pkg::ST_RUN, step_cnt_ff <= bet_pkg::STEP_FINAL, "step counter ran past the final step")

endmodule

[tb/baseline_extent_tracker_top_tb.sv]
// ----------------------------------------------------------------------------
// Baseline extent tracker testbench
// Sends rows of u, v, w and channel ranges through the tracker with random
// bursts on the row side and random stalls on the result side. Each accepted
// row is folded into a local model of the running extents, and every result
// beat is checked field by field against it. Runs over several scale settings.
// ----------------------------------------------------------------------------
module baseline_extent_tracker_top_tb;

   localparam int CHANNEL_BITS  = 16;
   localparam int SETTLE_CYCLES = 16;    // a little over the time one row takes
   localparam int REPORT_LIMIT  = 10;
   localparam int RANDOM_ROWS   = 1850;
   localparam int PHASES        = 6;
   localparam logic [15:0] CH_MASK = 16'((32'd1 << CHANNEL_BITS) - 1);
   localparam bet_pkg::csr_idx_type CSR_UNMAPPED = 8'hFF;

   typedef struct packed {
      logic signed [31:0] coord_u;
      logic signed [31:0] coord_v;
      logic signed [31:0] coord_w;
      logic        [15:0] first_channel;
      logic        [15:0] end_channel;
      logic               last_of_set;
   } row_type;

   // bound order: min_u, max_u, min_v, max_v, min_w, max_w
   typedef struct packed {
      logic [5:0][bet_pkg::BOUND_W-1:0] bound;
      logic                             any_included;
   } extent_type;

   typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_CHOKE, SINK_SLOW} sink_mode_type;

   // clock, reset and block inputs, all known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic               req_valid = 1'b0;
   logic signed [31:0] req_coord_u = '0;
   logic signed [31:0] req_coord_v = '0;
   logic signed [31:0] req_coord_w = '0;
   logic        [15:0] req_first_channel = '0;
   logic        [15:0] req_end_channel = '0;
   logic               req_last_of_set = 1'b0;
   logic               rsp_ready = 1'b0;
   logic               csr_valid = 1'b0;
   logic        [7:0]  csr_index = '0;
   logic        [31:0] csr_data = '0;

   logic               req_ready;
   logic               rsp_valid;
   logic signed [39:0] rsp_min_u, rsp_max_u, rsp_min_v, rsp_max_v, rsp_min_w, rsp_max_w;
   logic               rsp_any_included;
   logic               csr_ready;

   // model of the scales and running extents
   logic        [31:0] freq_cfg = '0;
   logic signed [31:0] step_cfg = '0;
   longint             lowest_q10 [3];
   longint             highest_q10 [3];
   bit                 seen_row;
   extent_type         pending_extents [$];

   int  fault_count = 0;
   int  burst_left = 0;
   bit  req_up = 1'b0;
   string bound_name [6] = '{"min_u", "max_u", "min_v", "max_v", "min_w", "max_w"};

   always #1 clock = ~clock;

   baseline_extent_tracker_top #(.CHANNEL_BITS(CHANNEL_BITS)) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_coord_u       (req_coord_u),
      .req_coord_v       (req_coord_v),
      .req_coord_w       (req_coord_w),
      .req_first_channel (req_first_channel),
      .req_end_channel   (req_end_channel),
      .req_last_of_set   (req_last_of_set),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_min_u         (rsp_min_u),
      .rsp_max_u         (rsp_max_u),
      .rsp_min_v         (rsp_min_v),
      .rsp_max_v         (rsp_max_v),
      .rsp_min_w         (rsp_min_w),
      .rsp_max_w         (rsp_max_w),
      .rsp_any_included  (rsp_any_included),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // ------------------------------------------------------------------------
   // Extent model
   // ------------------------------------------------------------------------
   function automatic void clear_extents();
      for (int j = 0; j < 3; j++) begin
         lowest_q10[j]  = longint'(bet_pkg::BOUND_HI);
         highest_q10[j] = longint'(bet_pkg::BOUND_LO);
      end
      seen_row = 1'b0;
   endfunction

   // base + channel * step, clamped to the unsigned Q8.24 range
   function automatic longint channel_scale_at(input logic [15:0] ch);
      longint s;
      s = longint'({32'd0, freq_cfg}) + longint'({48'd0, ch}) * longint'(step_cfg);
      if (s < 0)
         s = 0;
      else if (s > longint'({32'd0, bet_pkg::SCALE_MAX}))
         s = longint'({32'd0, bet_pkg::SCALE_MAX});
      return s;
   endfunction

   // scale times coordinate, floored back to 10 fraction bits
   function automatic longint to_wavelengths(input longint scale, input logic signed [31:0] c);
      longint p;
      p = scale * longint'(c);
      return p >>> 24;
   endfunction

   // fold one row into the extents; returns 1 when the row closes a set
   function automatic bit fold_row(input row_type row, output extent_type res);
      logic        [15:0] first_ch;
      logic        [15:0] end_ch;
      logic signed [31:0] c;
      longint s_first, s_last, at_first, at_last, lo, hi;
      first_ch = row.first_channel & CH_MASK;
      end_ch   = row.end_channel & CH_MASK;
      res      = '0;
      if (end_ch > first_ch) begin
         s_first  = channel_scale_at(first_ch);
         s_last   = channel_scale_at(end_ch - 16'd1);
         seen_row = 1'b1;
         for (int j = 0; j < 3; j++) begin
            c = (j == 0) ? row.coord_u : (j == 1) ? row.coord_v : row.coord_w;
            at_first = to_wavelengths(s_first, c);
            at_last  = to_wavelengths(s_last, c);
            // a negative coordinate turns the channel order round
            lo = (c >= 0) ? at_first : at_last;
            hi = (c >= 0) ? at_last : at_first;
            if (lo < lowest_q10[j]) lowest_q10[j] = lo;
            if (hi > highest_q10[j]) highest_q10[j] = hi;
         end
      end
      if (!row.last_of_set)
         return 1'b0;
      for (int j = 0; j < 3; j++) begin
         res.bound[2*j]   = lowest_q10[j][bet_pkg::BOUND_W-1:0];
         res.bound[2*j+1] = highest_q10[j][bet_pkg::BOUND_W-1:0];
      end
      res.any_included = seen_row;
      clear_extents();
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // Row sender and configuration writes
   // ------------------------------------------------------------------------
   function automatic row_type mk_row(input logic signed [31:0] u, input logic signed [31:0] v,
                                      input logic signed [31:0] w, input logic [15:0] first_ch,
                                      input logic [15:0] end_ch, input logic last);
      row_type r;
      r.coord_u = u;
      r.coord_v = v;
      r.coord_w = w;
      r.first_channel = first_ch;
      r.end_channel = end_ch;
      r.last_of_set = last;
      return r;
   endfunction

   task automatic release_req();
      if (req_up) begin
         req_valid <= 1'b0;
         req_up = 1'b0;
      end
   endtask

   // bursts of random length, with the odd long run, between short random gaps
   task automatic pace_sender();
      int gap;
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 12);
         release_req();
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                   : $urandom_range(0, 10);
      end
   endtask

   task automatic send_row(input row_type row);
      extent_type res;
      req_valid         <= 1'b1;
      req_coord_u       <= row.coord_u;
      req_coord_v       <= row.coord_v;
      req_coord_w       <= row.coord_w;
      req_first_channel <= row.first_channel;
      req_end_channel   <= row.end_channel;
      req_last_of_set   <= row.last_of_set;
      req_up = 1'b1;
      do @(posedge clock); while (!req_ready);
      if (fold_row(row, res))
         pending_extents.push_back(res);
      pace_sender();
   endtask

   // hold off the sender until every expected result beat has come back
   task automatic drain();
      release_req();
      do @(posedge clock); while (pending_extents.size() != 0);
   endtask

   // idle block: nothing expected, and any trailing row worked off
   task automatic settle();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input bet_pkg::csr_idx_type idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         bet_pkg::CSR_FREQ_SCALE: freq_cfg = data;
         bet_pkg::CSR_STEP_SCALE: step_cfg = data;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_scales(input logic [31:0] freq, input logic [31:0] step);
      write_csr(bet_pkg::CSR_FREQ_SCALE, freq);
      write_csr(bet_pkg::CSR_STEP_SCALE, step);
   endtask

   // ------------------------------------------------------------------------
   // Random rows
   // ------------------------------------------------------------------------
   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0, 1: return $urandom;
         2, 3: return 32'($urandom_range(0, 2097151)) - 32'd1048576;
         4: begin
            case ($urandom_range(0, 4))
               0: return 32'sh7FFF_FFFF;
               1: return 32'sh8000_0000;
               2: return 32'sd0;
               3: return -32'sd1;
               default: return 32'sd1;
            endcase
         end
         default: return 32'($urandom_range(0, 2046)) - 32'd1023;
      endcase
   endfunction

   function automatic row_type rand_row();
      row_type r;
      int first_ch, end_ch;
      r.coord_u = rand_coord();
      r.coord_v = rand_coord();
      r.coord_w = rand_coord();
      first_ch = $urandom_range(0, 65535);
      case ($urandom_range(0, 9))
         0: end_ch = $urandom_range(0, 65535);        // often an empty range
         1: end_ch = first_ch;
         2: begin
            first_ch = $urandom_range(0, 15);
            end_ch   = $urandom_range(65000, 65535);
         end
         default: end_ch = first_ch + $urandom_range(1, 64);
      endcase
      if (end_ch > 65535) end_ch = 65535;
      r.first_channel = 16'(first_ch);
      r.end_channel   = 16'(end_ch);
      r.last_of_set   = ($urandom_range(0, 4) == 0);
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // scales at their reset value of zero: every product is zero
   task automatic test_reset_scales();
      send_row(mk_row(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 16'd0, 16'hFFFF, 1'b1));
      send_row(mk_row(1, -1, 5, 16'd7, 16'd7, 1'b1));
   endtask

   // channel scale clamped high and low
   task automatic test_scale_clamp();
      settle();
      write_scales(32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_row(mk_row(32'sh7FFF_FFFF, 32'sh8000_0000, -1, 16'd0, 16'd1, 1'b0));
      send_row(mk_row(1, -1, 12345, 16'hFFFE, 16'hFFFF, 1'b0));
      send_row(mk_row(-12345, 99, 0, 16'd100, 16'hFFFF, 1'b1));
      settle();
      write_scales(32'hFFFF_FFFF, 32'h8000_0000);
      send_row(mk_row(32'sh7FFF_FFFF, 32'sh8000_0000, 3, 16'd0, 16'd3, 1'b1));
      send_row(mk_row(-77, 77, 32'sh8000_0000, 16'd0, 16'hFFFF, 1'b1));
   endtask

   // negative coordinates swap first and last channel, floors round down
   task automatic test_sign_swap();
      settle();
      write_scales(32'h0100_0000, 32'h0001_0000);
      send_row(mk_row(1024, -1024, 0, 16'd10, 16'd300, 1'b0));
      send_row(mk_row(-1, 1, -7, 16'd0, 16'd1, 1'b0));
      send_row(mk_row(32'sh1234_5678, -32'sh1234_5678, 1, 16'd500, 16'd20, 1'b1));
   endtask

   // sets with no included row report the cleared bounds
   task automatic test_empty_sets();
      send_row(mk_row(5, 5, 5, 16'hFFFF, 16'd0, 1'b0));
      send_row(mk_row(-5, 9, 1, 16'd3, 16'd3, 1'b1));
      send_row(mk_row(32'sh7FFF_FFFF, 0, -1, 16'd40, 16'd39, 1'b1));
   endtask

   // a write to an unmapped index leaves both scales alone
   task automatic test_unmapped_register();
      settle();
      write_csr(CSR_UNMAPPED, $urandom);
      send_row(mk_row(1000, -1000, 77, 16'd0, 16'd16, 1'b1));
   endtask

   task automatic test_random_sets();
      logic [31:0] freq, step;
      int rows_per_phase;
      rows_per_phase = RANDOM_ROWS / PHASES;
      for (int p = 0; p < PHASES; p++) begin
         settle();
         case (p)
            0: begin
               freq = $urandom_range(32'h0055_5555, 32'h0355_5555);
               step = 32'($urandom_range(0, 2048)) - 32'd1024;
            end
            1: begin freq = 32'd0;        step = 32'h7FFF_FFFF; end
            2: begin freq = 32'hFFFF_FFFF; step = 32'h8000_0000; end
            3: begin freq = $urandom;     step = $urandom;     end
            4: begin freq = 32'h8000_0000; step = 32'hFFFF_0000; end
            default: begin
               freq = $urandom_range(32'h0100_0000, 32'h0400_0000);
               step = 32'd0 - 32'($urandom_range(0, 4096));
            end
         endcase
         write_scales(freq, step);
         for (int i = 0; i < rows_per_phase; i++) begin
            send_row(rand_row());
            if ($urandom_range(0, 199) == 0) drain();
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Result side: stall pattern and checker
   // ------------------------------------------------------------------------
   sink_mode_type sink_mode = SINK_OPEN;
   int sink_left = 0;
   int stall_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (sink_left == 0) begin
            sink_mode  = sink_mode_type'($urandom_range(0, 3));
            sink_left  = $urandom_range(32, 400);
            stall_left = 0;
         end
         sink_left--;
         case (sink_mode)
            SINK_OPEN: rsp_ready <= 1'b1;
            SINK_COIN: rsp_ready <= ($urandom_range(0, 3) != 0);
            SINK_SLOW: rsp_ready <= ($urandom_range(0, 4) == 0);
            default: begin
               // open windows broken by long stalls
               if (stall_left != 0) begin
                  stall_left--;
                  rsp_ready <= 1'b0;
               end else begin
                  rsp_ready <= 1'b1;
                  if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(5, 30);
               end
            end
         endcase
      end
   end

   function automatic void log_fault(input string msg);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) $display("mismatch: %s", msg);
   endfunction

   always @(posedge clock) begin
      extent_type seen;
      extent_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.bound[0] = rsp_min_u;
         seen.bound[1] = rsp_max_u;
         seen.bound[2] = rsp_min_v;
         seen.bound[3] = rsp_max_v;
         seen.bound[4] = rsp_min_w;
         seen.bound[5] = rsp_max_w;
         seen.any_included = rsp_any_included;
         if (pending_extents.size() == 0) begin
            log_fault($sformatf("result beat with nothing expected, min_u %0d",
                                $signed(seen.bound[0])));
         end else begin
            want = pending_extents.pop_front();
            for (int i = 0; i < 6; i++)
               if (seen.bound[i] !== want.bound[i])
                  log_fault($sformatf("%s expected %0d, got %0d", bound_name[i],
                                      $signed(want.bound[i]), $signed(seen.bound[i])));
            if (seen.any_included !== want.any_included)
               log_fault($sformatf("any_included expected %b, got %b",
                                   want.any_included, seen.any_included));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sequence and run limit
   // ------------------------------------------------------------------------
   initial begin
      clear_extents();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_scales();
      test_scale_clamp();
      test_sign_swap();
      test_empty_sets();
      test_unmapped_register();
      test_random_sets();
      settle();
      if (fault_count == 0 && pending_extents.size() == 0)
         $display("baseline_extent_tracker_top_tb: PASS");
      else
         $display("baseline_extent_tracker_top_tb: FAIL");
      $finish;
   end

   initial begin
      #2000000;
      $display("baseline_extent_tracker_top_tb: FAIL");
      $finish;
   end

endmodule

[baseline_extent_tracker_top.f]
+incdir+rtl
rtl/bet_pkg.sv
rtl/baseline_extent_tracker_top.sv
tb/baseline_extent_tracker_top_tb.sv
